// ===== rtl/bale_pkg.sv =====
// ----------------------------------------------------------------------------
// bale_pkg
// Shared types and codes for the bounded array list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package bale_pkg;

  typedef enum logic [3:0] {
    MODE_CLEAR     = 4'd0,
    MODE_INSERT    = 4'd1,
    MODE_DELETE    = 4'd2,
    MODE_LOCATE    = 4'd3,
    MODE_REMOVE_MIN = 4'd4,
    MODE_REVERSE   = 4'd5,
    MODE_REMOVE_VAL = 4'd6,
    MODE_REMOVE_RNG = 4'd7,
    MODE_DEDUP     = 4'd8
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_FINISH,
    ST_RESULT
  } state_t;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_BADPOS = 2'd1;
  localparam logic [1:0] STATUS_FULL   = 2'd2;
  localparam logic [1:0] STATUS_EMPTY  = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/bounded_array_list_engine.sv =====
// ----------------------------------------------------------------------------
// bounded_array_list_engine
// Bounded list of signed 32-bit elements held in one synchronous RAM.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Payload
//   in_       request    in_valid / in_ready   mode, position, value, bounds
//   out_      result     out_valid / out_ready status, value, position, length
//
// Clear, rejected requests and requests with nothing to walk go from the
// accepting cycle straight to the result state, which loads the result
// register. Every other request walks the list through the single RAM port
// pair, each element in a read state and then an exec state acting on the
// registered read data; insert ends with a finish state for its final write
// (an insert at the end goes there directly), and reverse writes one element
// of each swapped pair there. Reset (synchronous, active low) empties the
// list; the RAM itself is not cleared, since only written slots are ever read.
// A result waits in the output register while the next request is accepted;
// the engine stalls in its result state only when that register is still full.
`default_nettype none

module bounded_array_list_engine #(
  parameter int LIST_DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic [3:0]         in_mode,
  input  wire logic [6:0]         in_position,
  input  wire logic signed [31:0] in_value,
  input  wire logic signed [31:0] in_range_low,
  input  wire logic signed [31:0] in_range_high,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic [1:0]         out_status,
  output      logic signed [31:0] out_result_value,
  output      logic [6:0]         out_result_position,
  output      logic [6:0]         out_new_length
);

  localparam int LW = $clog2(LIST_DEPTH + 1);
  localparam int AW = $clog2(LIST_DEPTH);
  localparam int CW = ((LW > 7) ? LW : 7) + 1;

  bale_pkg::state_t state_r, state_nxt;

  // Element storage: one write and one registered read per cycle.
  logic [31:0]        mem [LIST_DEPTH];
  logic signed [31:0] rdata_r;
  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [31:0]        wdata;

  logic [LW-1:0]      len_r, len_nxt;
  logic [LW-1:0]      idx_r, idx_nxt;
  logic [LW-1:0]      k_r, k_nxt;
  logic signed [31:0] tmp_r, tmp_nxt;
  logic               ph_r, ph_nxt;
  bale_pkg::mode_t    mode_r, mode_nxt;
  logic [6:0]         pos_r, pos_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic signed [31:0] lo_r, lo_nxt;
  logic signed [31:0] hi_r, hi_nxt;
  logic [1:0]         status_r, status_nxt;
  logic signed [31:0] rval_r, rval_nxt;
  logic [6:0]         rpos_r, rpos_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         o_status_r, o_status_nxt;
  logic signed [31:0] o_rval_r, o_rval_nxt;
  logic [6:0]         o_rpos_r, o_rpos_nxt;
  logic [6:0]         o_len_r, o_len_nxt;

  logic accept, out_free;
  logic [CW-1:0] pos_w, n_w, pos_m1;
  logic ins_bad, del_bad, is_full, is_last, ins_stop, min_take, keep, rev_more;
  logic [LW-1:0] k_min;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign raddr    = ph_r ? k_r[AW-1:0] : idx_r[AW-1:0];
  assign in_ready = (state_r == bale_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Checks on the incoming request against the current length.
  assign pos_w   = CW'(in_position);
  assign n_w     = CW'(len_r);
  assign ins_bad = (pos_w == '0) || (pos_w > n_w + CW'(1));
  assign del_bad = (pos_w == '0) || (pos_w > n_w);
  assign is_full = (len_r == LW'(LIST_DEPTH));

  // Per-element decisions on the registered read data.
  assign pos_m1   = CW'(pos_r) - CW'(1);
  assign is_last  = (idx_r == len_r - LW'(1));
  assign ins_stop = (CW'(idx_r) == pos_m1);
  assign min_take = (idx_r == '0) || (rdata_r < tmp_r);
  assign k_min    = min_take ? idx_r : k_r;
  assign rev_more = (idx_r + LW'(1)) < (k_r - LW'(1));

  always_comb begin
    case (mode_r)
      bale_pkg::MODE_REMOVE_VAL: keep = (rdata_r != val_r);
      bale_pkg::MODE_REMOVE_RNG: keep = !((lo_r < rdata_r) && (rdata_r < hi_r));
      default:                   keep = (idx_r == '0) || (rdata_r != tmp_r);
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bale_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = bale_pkg::ST_RESULT;
          case (in_mode) inside
            bale_pkg::MODE_INSERT: begin
              if (!ins_bad && !is_full) begin
                state_nxt = (pos_w <= n_w) ? bale_pkg::ST_READ : bale_pkg::ST_FINISH;
              end
            end
            bale_pkg::MODE_DELETE: begin
              if (!del_bad) state_nxt = bale_pkg::ST_READ;
            end
            bale_pkg::MODE_LOCATE, bale_pkg::MODE_REMOVE_MIN, bale_pkg::MODE_REMOVE_VAL,
            bale_pkg::MODE_DEDUP: begin
              if (len_r != '0) state_nxt = bale_pkg::ST_READ;
            end
            bale_pkg::MODE_REMOVE_RNG: begin
              if (len_r != '0 && !(in_range_high < in_range_low)) begin
                state_nxt = bale_pkg::ST_READ;
              end
            end
            bale_pkg::MODE_REVERSE: begin
              if (len_r > LW'(1)) state_nxt = bale_pkg::ST_READ;
            end
            default: state_nxt = bale_pkg::ST_RESULT;
          endcase
        end
      end
      bale_pkg::ST_READ: state_nxt = bale_pkg::ST_EXEC;
      bale_pkg::ST_EXEC: begin
        case (mode_r)
          bale_pkg::MODE_INSERT:
            state_nxt = ins_stop ? bale_pkg::ST_FINISH : bale_pkg::ST_READ;
          bale_pkg::MODE_LOCATE:
            state_nxt = (rdata_r == val_r || is_last) ? bale_pkg::ST_RESULT
                                                      : bale_pkg::ST_READ;
          bale_pkg::MODE_REVERSE:
            state_nxt = ph_r ? bale_pkg::ST_FINISH : bale_pkg::ST_READ;
          default:
            state_nxt = is_last ? bale_pkg::ST_RESULT : bale_pkg::ST_READ;
        endcase
      end
      bale_pkg::ST_FINISH: begin
        if (mode_r == bale_pkg::MODE_REVERSE && rev_more) state_nxt = bale_pkg::ST_READ;
        else state_nxt = bale_pkg::ST_RESULT;
      end
      bale_pkg::ST_RESULT: begin
        if (out_free) state_nxt = bale_pkg::ST_IDLE;
      end
      default: state_nxt = bale_pkg::ST_IDLE;
    endcase
  end

  // Datapath, RAM controls and result register.
  always_comb begin
    len_nxt = len_r;   idx_nxt = idx_r;   k_nxt = k_r;     tmp_nxt = tmp_r;
    ph_nxt = ph_r;     mode_nxt = mode_r; pos_nxt = pos_r; val_nxt = val_r;
    lo_nxt = lo_r;     hi_nxt = hi_r;     status_nxt = status_r;
    rval_nxt = rval_r; rpos_nxt = rpos_r;
    we = 1'b0;  waddr = idx_r[AW-1:0];  wdata = rdata_r;
    out_valid_nxt = out_valid_r && !out_ready;
    o_status_nxt = o_status_r; o_rval_nxt = o_rval_r;
    o_rpos_nxt = o_rpos_r;     o_len_nxt = o_len_r;

    unique case (state_r)
      bale_pkg::ST_IDLE: begin
        if (accept) begin
          mode_nxt = bale_pkg::mode_t'(in_mode);
          pos_nxt = in_position; val_nxt = in_value;
          lo_nxt = in_range_low; hi_nxt = in_range_high;
          status_nxt = bale_pkg::STATUS_OK;
          rval_nxt = '0; rpos_nxt = '0; ph_nxt = 1'b0;
          idx_nxt = '0; k_nxt = '0;
          case (in_mode)
            bale_pkg::MODE_CLEAR: len_nxt = '0;
            bale_pkg::MODE_INSERT: begin
              if (ins_bad) status_nxt = bale_pkg::STATUS_BADPOS;
              else if (is_full) status_nxt = bale_pkg::STATUS_FULL;
              idx_nxt = len_r - LW'(1);
            end
            bale_pkg::MODE_DELETE: begin
              if (del_bad) status_nxt = bale_pkg::STATUS_BADPOS;
              idx_nxt = LW'(pos_w - CW'(1));
            end
            bale_pkg::MODE_REMOVE_MIN: begin
              if (len_r == '0) status_nxt = bale_pkg::STATUS_EMPTY;
            end
            bale_pkg::MODE_REVERSE: k_nxt = len_r - LW'(1);
            default: ;
          endcase
        end
      end
      bale_pkg::ST_READ: ;
      bale_pkg::ST_EXEC: begin
        idx_nxt = idx_r + LW'(1);
        case (mode_r) inside
          bale_pkg::MODE_INSERT: begin
            we = 1'b1; waddr = AW'(idx_r + LW'(1));
            idx_nxt = idx_r - LW'(1);
          end
          bale_pkg::MODE_DELETE: begin
            if (ins_stop) rval_nxt = rdata_r;
            else begin
              we = 1'b1; waddr = AW'(idx_r - LW'(1));
            end
            if (is_last) len_nxt = len_r - LW'(1);
          end
          bale_pkg::MODE_LOCATE: begin
            if (rdata_r == val_r) rpos_nxt = 7'(idx_r + LW'(1));
          end
          bale_pkg::MODE_REMOVE_MIN: begin
            if (min_take) tmp_nxt = rdata_r;
            k_nxt = k_min;
            if (is_last) begin
              // The last element is in hand: it fills the minimum's slot.
              we = 1'b1; waddr = k_min[AW-1:0];
              rval_nxt = min_take ? rdata_r : tmp_r;
              rpos_nxt = 7'(k_min + LW'(1));
              len_nxt = len_r - LW'(1);
            end
          end
          bale_pkg::MODE_REVERSE: begin
            idx_nxt = idx_r;
            if (!ph_r) begin
              tmp_nxt = rdata_r; ph_nxt = 1'b1;
            end else begin
              we = 1'b1; ph_nxt = 1'b0;
            end
          end
          bale_pkg::MODE_REMOVE_VAL, bale_pkg::MODE_REMOVE_RNG,
          bale_pkg::MODE_DEDUP: begin
            if (keep) begin
              we = 1'b1; waddr = k_r[AW-1:0];
              k_nxt = k_r + LW'(1);
              tmp_nxt = rdata_r;
            end
            if (is_last) len_nxt = keep ? k_r + LW'(1) : k_r;
          end
          default: ;
        endcase
      end
      bale_pkg::ST_FINISH: begin
        we = 1'b1;
        if (mode_r == bale_pkg::MODE_REVERSE) begin
          waddr = k_r[AW-1:0]; wdata = tmp_r;
          idx_nxt = idx_r + LW'(1); k_nxt = k_r - LW'(1);
        end else begin
          waddr = AW'(pos_m1); wdata = val_r;
          len_nxt = len_r + LW'(1);
        end
      end
      bale_pkg::ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_status_nxt = status_r; o_rval_nxt = rval_r;
          o_rpos_nxt = rpos_r;     o_len_nxt = 7'(len_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bale_pkg::ST_IDLE;
      len_r <= '0;
      ph_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r <= len_nxt;
      ph_r <= ph_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;   k_r <= k_nxt;       tmp_r <= tmp_nxt;
    mode_r <= mode_nxt; pos_r <= pos_nxt;   val_r <= val_nxt;
    lo_r <= lo_nxt;     hi_r <= hi_nxt;     status_r <= status_nxt;
    rval_r <= rval_nxt; rpos_r <= rpos_nxt;
    o_status_r <= o_status_nxt; o_rval_r <= o_rval_nxt;
    o_rpos_r <= o_rpos_nxt;     o_len_r <= o_len_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = o_status_r;
  assign out_result_value    = o_rval_r;
  assign out_result_position = o_rpos_r;
  assign out_new_length      = o_len_r;

endmodule

`default_nettype wire

// ===== rtl/bale_checker.sv =====
// ----------------------------------------------------------------------------
// bale_checker
// Port-level checks for the bounded array list engine.
// ----------------------------------------------------------------------------
`default_nettype none

module bale_checker #(
  parameter int LIST_DEPTH = 64
) (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic [3:0]         in_mode,
  input wire logic [6:0]         in_position,
  input wire logic signed [31:0] in_value,
  input wire logic signed [31:0] in_range_low,
  input wire logic signed [31:0] in_range_high,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [1:0]         out_status,
  input wire logic signed [31:0] out_result_value,
  input wire logic [6:0]         out_result_position,
  input wire logic [6:0]         out_new_length
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_value)
                               && $stable(out_new_length))
    else $error("result changed while stalled");

  // A full list reports the full depth as its length.
  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == bale_pkg::STATUS_FULL |-> out_new_length == 7'(LIST_DEPTH))
    else $error("full status with wrong length");

  // Remove-min on an empty list leaves it empty and returns nothing.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == bale_pkg::STATUS_EMPTY |->
      out_new_length == '0 && out_result_value == '0 && out_result_position == '0)
    else $error("empty status with data");

  // A rejected position never returns an element.
  a_badpos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == bale_pkg::STATUS_BADPOS |->
      out_result_value == '0 && out_result_position == '0)
    else $error("bad position with data");

endmodule

bind bounded_array_list_engine bale_checker #(.LIST_DEPTH(LIST_DEPTH)) u_bale_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// List engine testbench
// Drives requests of every mode, and some undefined codes, into the bounded
// list engine, predicts every response with a behavioral copy of the list,
// and compares each response field by field under varying back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int DEPTH = 64;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [3:0]         mode;
    logic [6:0]         position;
    logic signed [31:0] value;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
  } list_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] result_value;
    logic [6:0]         result_position;
    logic [6:0]         new_length;
  } list_rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] in_mode = '0;
  logic [6:0] in_position = '0;
  logic signed [31:0] in_value = '0;
  logic signed [31:0] in_range_low = '0;
  logic signed [31:0] in_range_high = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic signed [31:0] out_result_value;
  logic [6:0] out_result_position;
  logic [6:0] out_new_length;

  always #5 clk = ~clk;

  bounded_array_list_engine #(.LIST_DEPTH(DEPTH)) dut (.*);

  // Requests waiting for the driver and responses waiting for the monitor.
  list_req_t pending_reqs[$];
  list_rsp_t expected_rsps[$];

  // Shadow copy of the list used by the predictor, plus a length mirror that
  // the stimulus generator uses to aim positions at legal slots.
  logic signed [31:0] shadow_list[DEPTH];
  int shadow_len = 0;
  int gen_len = 0;
  logic signed [31:0] gen_vals[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit stim_done = 1'b0;
  int mismatches = 0;
  longint cycles = 0;

  // Apply one request to the shadow list and return the response it yields.
  function automatic list_rsp_t predict_list_op(list_req_t r);
    list_rsp_t rsp;
    int n;
    int k;
    logic signed [31:0] t;
    n = shadow_len;
    rsp = '0;
    case (r.mode)
      bale_pkg::MODE_CLEAR: n = 0;
      bale_pkg::MODE_INSERT: begin
        if (r.position < 1 || r.position > n + 1) rsp.status = bale_pkg::STATUS_BADPOS;
        else if (n >= DEPTH) rsp.status = bale_pkg::STATUS_FULL;
        else begin
          for (int i = n; i >= r.position; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[r.position-1] = r.value;
          n++;
        end
      end
      bale_pkg::MODE_DELETE: begin
        if (r.position < 1 || r.position > n) rsp.status = bale_pkg::STATUS_BADPOS;
        else begin
          rsp.result_value = shadow_list[r.position-1];
          for (int i = r.position; i < n; i++) shadow_list[i-1] = shadow_list[i];
          n--;
        end
      end
      bale_pkg::MODE_LOCATE: begin
        for (int i = 0; i < n; i++) begin
          if (shadow_list[i] == r.value) begin
            rsp.result_position = 7'(i + 1);
            break;
          end
        end
      end
      bale_pkg::MODE_REMOVE_MIN: begin
        if (n == 0) rsp.status = bale_pkg::STATUS_EMPTY;
        else begin
          k = 0;
          for (int i = 1; i < n; i++) if (shadow_list[i] < shadow_list[k]) k = i;
          rsp.result_value = shadow_list[k];
          rsp.result_position = 7'(k + 1);
          shadow_list[k] = shadow_list[n-1];
          n--;
        end
      end
      bale_pkg::MODE_REVERSE: begin
        for (int i = 0; i < n / 2; i++) begin
          t = shadow_list[i];
          shadow_list[i] = shadow_list[n-1-i];
          shadow_list[n-1-i] = t;
        end
      end
      bale_pkg::MODE_REMOVE_VAL: begin
        k = 0;
        for (int i = 0; i < n; i++)
          if (shadow_list[i] != r.value) shadow_list[k++] = shadow_list[i];
        n = k;
      end
      bale_pkg::MODE_REMOVE_RNG: begin
        if (!(r.range_high < r.range_low)) begin
          k = 0;
          for (int i = 0; i < n; i++) begin
            t = shadow_list[i];
            if (!(r.range_low < t && t < r.range_high)) shadow_list[k++] = t;
          end
          n = k;
        end
      end
      bale_pkg::MODE_DEDUP: begin
        if (n > 0) begin
          k = 1;
          for (int i = 1; i < n; i++)
            if (shadow_list[i] != shadow_list[k-1]) shadow_list[k++] = shadow_list[i];
          n = k;
        end
      end
      default: ;
    endcase
    shadow_len = n;
    rsp.new_length = 7'(n);
    return rsp;
  endfunction

  // Values drawn from a small pool so that locate, removal and dedup hit,
  // mixed with full-range random words and the signed extremes.
  function automatic logic signed [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return 32'(signed'($urandom_range(0, 8)) - 4);
    if (sel == 5) return 32'h8000_0000;
    if (sel == 6) return 32'h7fff_ffff;
    if (sel == 7 && gen_vals.size() > 0) return gen_vals[$urandom_range(0, gen_vals.size()-1)];
    return $urandom;
  endfunction

  // Queue one request, tracking the expected length so later positions
  // can be aimed inside the list. A negative length means it is unknown.
  task automatic queue_req(logic [3:0] mode, logic [6:0] pos, logic signed [31:0] v,
                           logic signed [31:0] lo, logic signed [31:0] hi);
    list_req_t r;
    r.mode = mode;
    r.position = pos;
    r.value = v;
    r.range_low = lo;
    r.range_high = hi;
    pending_reqs.push_back(r);
    gen_vals.push_back(v);
    if (gen_vals.size() > 32) void'(gen_vals.pop_front());
    if (mode == bale_pkg::MODE_CLEAR) gen_len = 0;
    else if (gen_len >= 0 && mode == bale_pkg::MODE_INSERT && pos >= 1 &&
             pos <= gen_len + 1 && gen_len < DEPTH)
      gen_len++;
    else if (gen_len >= 0 && mode == bale_pkg::MODE_DELETE && pos >= 1 && pos <= gen_len)
      gen_len--;
    else if (mode == bale_pkg::MODE_REMOVE_MIN && gen_len > 0) gen_len--;
    else if (mode >= bale_pkg::MODE_REMOVE_VAL && mode <= bale_pkg::MODE_DEDUP) gen_len = -1;
  endtask

  task automatic queue_random_req();
    int sel;
    int len_guess;
    logic signed [31:0] a;
    logic signed [31:0] b;
    sel = $urandom_range(0, 99);
    len_guess = (gen_len < 0) ? DEPTH : gen_len;
    a = pick_value();
    b = pick_value();
    if (sel < 45)
      queue_req(bale_pkg::MODE_INSERT, ($urandom_range(0, 9) == 0) ? 7'($urandom) :
                7'($urandom_range(1, len_guess + 1)), pick_value(), $urandom, $urandom);
    else if (sel < 55)
      queue_req(bale_pkg::MODE_DELETE, ($urandom_range(0, 9) == 0) ? 7'($urandom) :
                7'($urandom_range(1, len_guess > 0 ? len_guess : 1)), $urandom, $urandom,
                $urandom);
    else if (sel < 63)
      queue_req(bale_pkg::MODE_LOCATE, 7'($urandom), pick_value(), $urandom, $urandom);
    else if (sel < 70)
      queue_req(bale_pkg::MODE_REMOVE_MIN, 7'($urandom), $urandom, $urandom, $urandom);
    else if (sel < 75)
      queue_req(bale_pkg::MODE_REVERSE, 7'($urandom), $urandom, $urandom, $urandom);
    else if (sel < 80)
      queue_req(bale_pkg::MODE_REMOVE_VAL, 7'($urandom), pick_value(), $urandom, $urandom);
    else if (sel < 86)
      queue_req(bale_pkg::MODE_REMOVE_RNG, 7'($urandom), $urandom, (a < b) ? a : b,
                (a < b) ? b : a);
    else if (sel < 88) queue_req(bale_pkg::MODE_REMOVE_RNG, 7'($urandom), $urandom, a, b);
    else if (sel < 94)
      queue_req(bale_pkg::MODE_DEDUP, 7'($urandom), $urandom, $urandom, $urandom);
    else if (sel < 96)
      queue_req(bale_pkg::MODE_CLEAR, 7'($urandom), $urandom, $urandom, $urandom);
    else queue_req(4'($urandom_range(9, 15)), 7'($urandom), $urandom, $urandom, $urandom);
  endtask

  // Driver: offers the head of the pending queue; the payload is held until
  // the request is taken, and idle gaps are only inserted between requests.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        void'(pending_reqs.pop_front());
        expected_rsps.push_back(predict_list_op({in_mode, in_position, in_value,
                                                 in_range_low, in_range_high}));
      end
      if ((!in_valid || in_ready) ) begin
        if (pending_reqs.size() > (in_valid && in_ready ? 0 : 0) &&
            pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          {in_mode, in_position, in_value, in_range_low, in_range_high} <= pending_reqs[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted response against the oldest prediction.
  always @(posedge clk) begin
    list_rsp_t want;
    cycles <= cycles + 1;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_rsps.size() == 0) begin
          $error("unexpected response: status %0d length %0d", out_status, out_new_length);
          mismatches++;
        end else begin
          want = expected_rsps.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            mismatches++;
          end
          if (out_result_value !== want.result_value) begin
            $error("result_value: expected %0d, got %0d", want.result_value, out_result_value);
            mismatches++;
          end
          if (out_result_position !== want.result_position) begin
            $error("result_position: expected %0d, got %0d", want.result_position,
                   out_result_position);
            mismatches++;
          end
          if (out_new_length !== want.new_length) begin
            $error("new_length: expected %0d, got %0d", want.new_length, out_new_length);
            mismatches++;
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: empty-list corner cases, bounds, extremes and ties.
    queue_req(bale_pkg::MODE_REMOVE_MIN, 0, 0, 0, 0);
    queue_req(bale_pkg::MODE_DELETE, 1, 0, 0, 0);
    queue_req(bale_pkg::MODE_LOCATE, 0, 5, 0, 0);
    queue_req(bale_pkg::MODE_REVERSE, 0, 0, 0, 0);
    queue_req(bale_pkg::MODE_DEDUP, 0, 0, 0, 0);
    queue_req(bale_pkg::MODE_INSERT, 0, 1, 0, 0);
    queue_req(bale_pkg::MODE_INSERT, 2, 1, 0, 0);
    queue_req(bale_pkg::MODE_INSERT, 1, 32'h7fff_ffff, 0, 0);
    queue_req(bale_pkg::MODE_INSERT, 1, 32'h8000_0000, 0, 0);
    queue_req(bale_pkg::MODE_INSERT, 3, 32'h8000_0000, 0, 0);
    queue_req(bale_pkg::MODE_INSERT, 2, 7, 0, 0);
    queue_req(bale_pkg::MODE_LOCATE, 0, 32'h7fff_ffff, 0, 0);
    queue_req(bale_pkg::MODE_REMOVE_MIN, 0, 0, 0, 0);
    queue_req(bale_pkg::MODE_REVERSE, 0, 0, 0, 0);
    queue_req(bale_pkg::MODE_DELETE, 7'h7f, 0, 0, 0);
    queue_req(bale_pkg::MODE_REMOVE_RNG, 0, 0, 10, 0);
    queue_req(bale_pkg::MODE_REMOVE_RNG, 0, 0, 32'h8000_0000, 32'h7fff_ffff);
    queue_req(4'hf, 7'h7f, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    queue_req(bale_pkg::MODE_CLEAR, 0, 0, 0, 0);
    // Fill to capacity, then two rejected inserts, dedup, value removal and a delete.
    for (int i = 0; i < DEPTH; i++) queue_req(bale_pkg::MODE_INSERT, 7'(i + 1), i / 3, 0, 0);
    queue_req(bale_pkg::MODE_INSERT, 7'(DEPTH + 1), 1, 0, 0);
    queue_req(bale_pkg::MODE_INSERT, 1, 1, 0, 0);
    queue_req(bale_pkg::MODE_DEDUP, 0, 0, 0, 0);
    queue_req(bale_pkg::MODE_REMOVE_VAL, 0, 4, 0, 0);
    queue_req(bale_pkg::MODE_DELETE, 1, 0, 0, 0);
    wait_drained();

    // Random part in four back-pressure phases.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 66 : 33) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 66 : 33) : 0;
      for (int i = 0; i < 290; i++) queue_random_req();
      // Hold off until every queued response is back.
      wait_drained();
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && expected_rsps.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("Mismatches found");
    $finish;
  end

endmodule
